// File: hw/rtl/pwmpw_pkg.sv
// Shared types and constants for the PWM input pulse-width meter.
`default_nettype none
package pwmpw_pkg;

  localparam int CH_COUNT   = 16;
  localparam int CH_W       = 4;
  localparam int TICK_BITS  = 24;
  localparam int MS_W       = 32;

  // Divisor is reload + 1; the clamped tick difference fits in TICK_BITS + 1 bits
  localparam int DEN_W      = TICK_BITS + 1;
  localparam int TICKS_W    = TICK_BITS + 1;
  localparam int US_W       = 10;
  localparam int NUM_W      = TICKS_W + US_W;
  localparam int WHOLE_US_W = MS_W + US_W;
  localparam int TOTAL_W    = WHOLE_US_W + 1;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

  localparam logic [US_W-1:0]      US_PER_MS   = US_W'(1000);
  localparam logic [TICK_BITS-1:0] RELOAD_INIT = TICK_BITS'(167999);

  typedef struct packed {
    logic [CH_W-1:0]      channel;
    logic [MS_W-1:0]      ms_stamp;
    logic [TICK_BITS-1:0] tick_stamp;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_channel;
    logic            width_valid;
    logic [31:0]     pulse_width_us;
    logic [31:0]     period_ms;
  } out_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/pwmpw_div.sv
// Restoring divider, one quotient bit per cycle, for the tick fraction.
`default_nettype none
module pwmpw_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pwmpw_pkg::NUM_W-1:0] dividend,
  input  wire logic [pwmpw_pkg::DEN_W-1:0] divisor,
  output logic                             busy,
  output logic [pwmpw_pkg::NUM_W-1:0]      quotient
);

  logic [pwmpw_pkg::DIV_CNT_W-1:0] cnt;
  logic [pwmpw_pkg::DEN_W-1:0]     den;
  logic [pwmpw_pkg::DEN_W-1:0]     rem;
  logic [pwmpw_pkg::NUM_W-1:0]     shreg;
  logic [pwmpw_pkg::DEN_W:0]       trial;
  logic                            qbit;
  logic [pwmpw_pkg::DEN_W:0]       trial_sub;

  // One trial subtraction per step
  always_comb begin
    trial     = {rem, shreg[pwmpw_pkg::NUM_W-1]};
    qbit      = (trial >= {1'b0, den});
    trial_sub = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= pwmpw_pkg::DIV_CNT_W'(pwmpw_pkg::NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      den   <= divisor;
      rem   <= '0;
    end else if (cnt != '0) begin
      shreg <= {shreg[pwmpw_pkg::NUM_W-2:0], qbit};
      rem   <= qbit ? trial_sub[pwmpw_pkg::DEN_W-1:0] : trial[pwmpw_pkg::DEN_W-1:0];
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = shreg;

endmodule
`default_nettype wire

// File: hw/rtl/pwm_input_pulse_width_meter_top.sv
// Top level of the PWM input pulse-width meter.
//
// Input channel (in_valid/in_ready/in_data): one edge event per item, carrying the
// channel and the down-counting ms and tick stamps taken at the edge.
// Output channel (out_valid/out_ready/out_data): exactly one result per item.
// A rising edge reports the ms period since the previous rising edge; a falling
// edge reports the high time in microseconds, saturated at 2^32-1.
// Per-channel rising-edge stamps sit in a 16-entry synchronous memory, read on
// accept and, for a rising edge, written back in the next cycle. Arm flags and
// entry valid bits are flip-flops.
// A rising edge passes through S_READ and S_PUSH; a falling edge through S_READ,
// S_MUL, S_DIV (the 35-step restoring divider by reload + 1), S_SUM and S_PUSH.
// One item is in work at a time; the next item is taken as soon as the result
// has moved to the output register, even if the receiver has not taken it yet.
// A stalled receiver holds the output register and the block stops taking
// items once a second result is ready.
// Reset (synchronous, rst): all channels armed for a rising edge, stored stamps
// read as zero, tick_reload back to 167999. cfg_we writes tick_reload at once.
`default_nettype none
module pwm_input_pulse_width_meter_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pwmpw_pkg::TICK_BITS-1:0]   cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire pwmpw_pkg::in_item_t               in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output pwmpw_pkg::out_item_t                   out_data
);

  localparam int ENT_W = pwmpw_pkg::MS_W + pwmpw_pkg::TICK_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV,
    S_SUM,
    S_PUSH
  } state_t;

  state_t state;

  logic [pwmpw_pkg::TICK_BITS-1:0] tick_reload;

  // Stamp memory and its per-entry bookkeeping
  logic [ENT_W-1:0]                stamp_mem [pwmpw_pkg::CH_COUNT];
  logic [ENT_W-1:0]                rd_q;
  logic [pwmpw_pkg::CH_COUNT-1:0]  ent_valid;
  logic [pwmpw_pkg::CH_COUNT-1:0]  await_falling;
  logic                            rd_valid;

  // Current item
  pwmpw_pkg::in_item_t             cur;
  pwmpw_pkg::out_item_t            res;

  logic [pwmpw_pkg::MS_W-1:0]       whole;
  logic [pwmpw_pkg::TICKS_W-1:0]    ticks;
  logic [pwmpw_pkg::NUM_W-1:0]      frac_num;
  logic [pwmpw_pkg::WHOLE_US_W-1:0] whole_us;
  logic [pwmpw_pkg::DEN_W-1:0]      div_den;

  // Combinational terms
  logic [pwmpw_pkg::MS_W-1:0]       rise_ms;
  logic [pwmpw_pkg::TICK_BITS-1:0]  rise_tick;
  logic [pwmpw_pkg::MS_W-1:0]       d_ms;
  logic [pwmpw_pkg::TICKS_W+1:0]    tick_sum;
  logic [pwmpw_pkg::TICKS_W-1:0]    ticks_next;
  logic [pwmpw_pkg::MS_W-1:0]       whole_next;
  logic [pwmpw_pkg::TOTAL_W-1:0]    total;
  logic [31:0]                      width_sat;
  logic                             div_start;
  logic                             div_busy;
  logic [pwmpw_pkg::NUM_W-1:0]      div_q;
  logic                             push_ok;

  assign in_ready = (state == S_IDLE);
  assign push_ok  = !out_valid || out_ready;
  assign div_start = (state == S_MUL);

  // Read data of an entry never written counts as zero
  always_comb begin
    rise_ms   = rd_valid ? rd_q[ENT_W-1 -: pwmpw_pkg::MS_W] : '0;
    rise_tick = rd_valid ? rd_q[pwmpw_pkg::TICK_BITS-1:0] : '0;
    d_ms      = rise_ms - cur.ms_stamp;
    div_den   = {1'b0, tick_reload} + 1'b1;

    // Tick difference, borrowing one ms of ticks when a boundary was crossed
    tick_sum = (pwmpw_pkg::TICKS_W+2)'(rise_tick)
             + ((d_ms != '0) ? (pwmpw_pkg::TICKS_W+2)'(div_den) : '0)
             - (pwmpw_pkg::TICKS_W+2)'(cur.tick_stamp);
    ticks_next = tick_sum[pwmpw_pkg::TICKS_W+1] ? '0 : tick_sum[pwmpw_pkg::TICKS_W-1:0];
    whole_next = (d_ms != '0) ? d_ms - 1'b1 : '0;

    // Final sum with saturation
    total     = pwmpw_pkg::TOTAL_W'(whole_us) + pwmpw_pkg::TOTAL_W'(div_q);
    width_sat = (total[pwmpw_pkg::TOTAL_W-1:32] != '0) ? '1 : total[31:0];
  end

  // Stamp memory: read on accept, write back on a rising edge
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rd_q <= stamp_mem[in_data.channel];
    end
    if (state == S_READ && !await_falling[cur.channel]) begin
      stamp_mem[cur.channel] <= {cur.ms_stamp, cur.tick_stamp};
    end
  end

  // Control, flags and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      ent_valid     <= '0;
      await_falling <= '0;
      tick_reload   <= pwmpw_pkg::RELOAD_INIT;
    end else begin
      if (cfg_we) begin
        tick_reload <= cfg_wdata;
      end
      // Output register empties on take; S_PUSH refills it below
      if (out_valid && out_ready && state != S_PUSH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur      <= in_data;
            rd_valid <= ent_valid[in_data.channel];
            state    <= S_READ;
          end
        end
        S_READ: begin
          res.out_channel <= cur.channel;
          if (!await_falling[cur.channel]) begin
            res.width_valid    <= 1'b0;
            res.pulse_width_us <= '0;
            res.period_ms      <= d_ms;
            ent_valid[cur.channel]     <= 1'b1;
            await_falling[cur.channel] <= 1'b1;
            state <= S_PUSH;
          end else begin
            res.width_valid <= 1'b1;
            res.period_ms   <= '0;
            ticks <= ticks_next;
            whole <= whole_next;
            await_falling[cur.channel] <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          res.pulse_width_us <= width_sat;
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push_ok) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Products by 1000: the tick product feeds the divider unregistered, the whole-ms product is registered for the sum
  always_comb begin
    frac_num = pwmpw_pkg::NUM_W'(ticks) * pwmpw_pkg::NUM_W'(pwmpw_pkg::US_PER_MS);
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      whole_us <= pwmpw_pkg::WHOLE_US_W'(whole)
                * pwmpw_pkg::WHOLE_US_W'(pwmpw_pkg::US_PER_MS);
    end
  end

  pwmpw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (frac_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

endmodule
`default_nettype wire

// File: verif/tb_pwm_input_pulse_width_meter_top.sv
// Self-checking testbench for the PWM input pulse-width meter top level.
module tb_pwm_input_pulse_width_meter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int NUM_PHASES = 7;
  localparam int NUM_ROWS = 18;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PERIODIC,
    RDY_SPARSE
  } ready_mode_t;

  // One row of the directed edge table; result used only when known is set
  typedef struct packed {
    pwmpw_pkg::in_item_t  item;
    logic                 known;
    pwmpw_pkg::out_item_t result;
  } edge_row_t;

  // Directed edges, run with the reset reload of 167999
  localparam edge_row_t EDGE_TABLE [NUM_ROWS] = '{
    // first rising edge at zero stamps, then a zero-width pulse
    '{'{4'd0, 32'd0, 24'd0}, 1'b1, '{4'd0, 1'b0, 32'd0, 32'd0}},
    '{'{4'd0, 32'd0, 24'd0}, 1'b1, '{4'd0, 1'b1, 32'd0, 32'd0}},
    // first rise after reset wraps, then a negative tick difference clamps
    '{'{4'd1, 32'd100, 24'd1000}, 1'b1, '{4'd1, 1'b0, 32'd0, 32'hFFFF_FF9C}},
    '{'{4'd1, 32'd100, 24'd2000}, 1'b1, '{4'd1, 1'b1, 32'd0, 32'd0}},
    // all-ones stamps, then a huge width that saturates
    '{'{4'd2, 32'hFFFF_FFFF, 24'hFF_FFFF}, 1'b1, '{4'd2, 1'b0, 32'd0, 32'd1}},
    '{'{4'd2, 32'd0, 24'd0}, 1'b1, '{4'd2, 1'b1, 32'hFFFF_FFFF, 32'd0}},
    // boundary crossed over several ms
    '{'{4'd3, 32'd5000, 24'd100000}, 1'b0, '0},
    '{'{4'd3, 32'd4990, 24'd50000}, 1'b0, '0},
    // normal period, then a pulse inside the same ms
    '{'{4'd3, 32'd4000, 24'd167999}, 1'b1, '{4'd3, 1'b0, 32'd0, 32'd1000}},
    '{'{4'd3, 32'd4000, 24'd0}, 1'b0, '0},
    // a single boundary crossed, tiny fraction
    '{'{4'd4, 32'd1, 24'd0}, 1'b0, '0},
    '{'{4'd4, 32'd0, 24'd167999}, 1'b0, '0},
    // alternating bit patterns on the top channel
    '{'{4'd15, 32'hAAAA_AAAA, 24'h55_5555}, 1'b0, '0},
    '{'{4'd15, 32'h5555_5555, 24'hAA_AAAA}, 1'b0, '0},
    '{'{4'd15, 32'h5555_5555, 24'd0}, 1'b0, '0},
    // tick stamp above the reload with a boundary crossed
    '{'{4'd15, 32'h5555_5554, 24'hFF_FFFF}, 1'b0, '0},
    // second rise on a channel after a full pulse
    '{'{4'd0, 32'd10, 24'd0}, 1'b0, '0},
    '{'{4'd0, 32'd10, 24'd0}, 1'b0, '0}
  };

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [pwmpw_pkg::TICK_BITS-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  pwmpw_pkg::in_item_t             in_data;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  pwmpw_pkg::out_item_t            out_data;

  // Predictor state: per-channel arm flag and rising-edge stamps, plus reload
  logic                            arm_fall_q [pwmpw_pkg::CH_COUNT];
  logic [pwmpw_pkg::MS_W-1:0]      rise_ms_q [pwmpw_pkg::CH_COUNT];
  logic [pwmpw_pkg::TICK_BITS-1:0] rise_tick_q [pwmpw_pkg::CH_COUNT];
  logic [pwmpw_pkg::TICK_BITS-1:0] reload_q;

  pwmpw_pkg::out_item_t pending_results [$];
  int                   errors = 0;
  int                   cycle_count = 0;
  ready_mode_t          ready_mode = RDY_ALWAYS;
  int                   ready_step = 0;

  pwm_input_pulse_width_meter_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // High time in us: whole ms plus scaled tick fraction, clamped and saturated
  function automatic logic [31:0] high_time_us(
      logic [pwmpw_pkg::CH_W-1:0]      ch,
      logic [pwmpw_pkg::MS_W-1:0]      ms,
      logic [pwmpw_pkg::TICK_BITS-1:0] tk);
    logic [pwmpw_pkg::TICK_BITS:0] div;
    logic [pwmpw_pkg::MS_W-1:0]    ms_diff;
    longint                        ticks;
    longint unsigned               whole;
    longint unsigned               frac;
    longint unsigned               total;
    div = {1'b0, reload_q} + 1'b1;
    ms_diff = rise_ms_q[ch] - ms;
    ticks = longint'(rise_tick_q[ch]);
    whole = 0;
    if (ms_diff != 0) begin
      whole = ms_diff - 1;
      ticks = ticks + longint'(div);
    end
    ticks = ticks - longint'(tk);
    if (ticks < 0) ticks = 0;
    frac = ($unsigned(ticks) * 1000) / div;
    total = whole * 1000 + frac;
    if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
    return total[31:0];
  endfunction

  // Advance the channel state for one edge and return its result
  function automatic pwmpw_pkg::out_item_t meter_step(pwmpw_pkg::in_item_t it);
    pwmpw_pkg::out_item_t r;
    r = '0;
    r.out_channel = it.channel;
    if (!arm_fall_q[it.channel]) begin
      r.period_ms = rise_ms_q[it.channel] - it.ms_stamp;
      rise_ms_q[it.channel] = it.ms_stamp;
      rise_tick_q[it.channel] = it.tick_stamp;
      arm_fall_q[it.channel] = 1'b1;
    end else begin
      r.width_valid = 1'b1;
      r.pulse_width_us = high_time_us(it.channel, it.ms_stamp, it.tick_stamp);
      arm_fall_q[it.channel] = 1'b0;
    end
    return r;
  endfunction

  // Present one edge and hold it until accepted, then record its result
  task automatic send_edge(pwmpw_pkg::in_item_t it, logic known,
                           pwmpw_pkg::out_item_t known_res);
    pwmpw_pkg::out_item_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    res = meter_step(it);
    if (known) res = known_res;
    pending_results.push_back(res);
  endtask

  // Drop valid for a number of cycles
  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Wait until every outstanding result has come out
  task automatic drain;
    hold_off(1);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly plausible pulse trains per channel, with some raw noise
  task automatic random_edges(int count, logic gaps_on);
    pwmpw_pkg::in_item_t it;
    int                  burst_left;
    burst_left = $urandom_range(1, 16);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 1)
        it.channel = pwmpw_pkg::CH_W'($urandom_range(0, 3));
      else
        it.channel = pwmpw_pkg::CH_W'($urandom_range(0, pwmpw_pkg::CH_COUNT - 1));
      if ($urandom_range(0, 9) < 7) begin
        if (arm_fall_q[it.channel]) begin
          if ($urandom_range(0, 7) == 0)
            it.ms_stamp = rise_ms_q[it.channel] - $urandom_range(0, 5000000);
          else
            it.ms_stamp = rise_ms_q[it.channel] - $urandom_range(0, 3);
        end else begin
          it.ms_stamp = rise_ms_q[it.channel] - $urandom_range(1, 50);
        end
        it.tick_stamp = pwmpw_pkg::TICK_BITS'($urandom_range(0, reload_q));
      end else begin
        it.ms_stamp = $urandom;
        it.tick_stamp = pwmpw_pkg::TICK_BITS'($urandom);
      end
      send_edge(it, 1'b0, '0);
      burst_left = burst_left - 1;
      if (gaps_on && burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) hold_off($urandom_range(20, 60));
        else hold_off($urandom_range(1, 6));
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    ready_step <= (ready_step == 6) ? 0 : ready_step + 1;
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_RANDOM: out_ready <= ($urandom_range(0, 9) >= 3);
      RDY_PERIODIC: out_ready <= (ready_step >= 3);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare one result field and report a mismatch
  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    pwmpw_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        report_field("out_channel", 32'(want.out_channel), 32'(out_data.out_channel));
        report_field("width_valid", 32'(want.width_valid), 32'(out_data.width_valid));
        report_field("pulse_width_us", want.pulse_width_us, out_data.pulse_width_us);
        report_field("period_ms", want.period_ms, out_data.period_ms);
      end
    end
  end

  // Main sequence
  initial begin
    logic [pwmpw_pkg::TICK_BITS-1:0] reload_val;
    ready_mode_t                     mode;
    logic                            gaps_on;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    reload_q = pwmpw_pkg::RELOAD_INIT;
    for (int c = 0; c < pwmpw_pkg::CH_COUNT; c++) begin
      arm_fall_q[c] = 1'b0;
      rise_ms_q[c] = '0;
      rise_tick_q[c] = '0;
    end
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed edges at the reset reload
    for (int r = 0; r < NUM_ROWS; r++)
      send_edge(EDGE_TABLE[r].item, EDGE_TABLE[r].known, EDGE_TABLE[r].result);
    drain();

    // Random phases, each with its own reload and stall pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      gaps_on = 1'b1;
      case (p)
        0: begin reload_val = 24'hFF_FFFF; mode = RDY_ALWAYS; gaps_on = 1'b0; end
        1: begin reload_val = 24'd1; mode = RDY_RANDOM; end
        2: begin reload_val = 24'd0; mode = RDY_PERIODIC; end
        3: begin reload_val = 24'd999; mode = RDY_SPARSE; end
        4: begin
          reload_val = pwmpw_pkg::TICK_BITS'($urandom_range(2, 5000));
          mode = RDY_RANDOM;
          gaps_on = 1'b0;
        end
        5: begin
          reload_val = pwmpw_pkg::TICK_BITS'($urandom_range(1, 24'hFF_FFFF));
          mode = RDY_PERIODIC;
        end
        default: begin reload_val = pwmpw_pkg::RELOAD_INIT; mode = RDY_RANDOM; end
      endcase
      // Register write while the block is idle
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= reload_val;
      ready_mode <= mode;
      reload_q = reload_val;
      @(negedge clk);
      cfg_we <= 1'b0;
      random_edges(ITEMS_PER_PHASE, gaps_on);
      drain();
    end

    repeat (50) @(negedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pwmpw_pkg.sv
hw/rtl/pwmpw_div.sv
hw/rtl/pwm_input_pulse_width_meter_top.sv
verif/tb_pwm_input_pulse_width_meter_top.sv
